// ===== design/mrrpm_pkg.sv =====
// ----------------------------------------------------------------------------
// mrrpm_pkg
// Shared types and constants for the multi-reader ring pointer manager.
// ----------------------------------------------------------------------------
package mrrpm_pkg;

    localparam int MAX_BYTES       = 4096;
    localparam int NUM_READERS_DEF = 4;

    localparam int BUF_SIZE_W = 13;
    localparam int POS_W      = 13;
    localparam int AMOUNT_W   = 13;
    localparam int ACTION_W   = 3;
    localparam int SLOT_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int SPACE_W    = 16;

    localparam logic [BUF_SIZE_W-1:0] BUF_SIZE_RST = BUF_SIZE_W'(4096);

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE_ASK    = 3'd0,
        ACT_WRITE_COMMIT = 3'd1,
        ACT_READ_ASK     = 3'd2,
        ACT_READ_COMMIT  = 3'd3,
        ACT_ATTACH       = 3'd4,
        ACT_DETACH       = 3'd5,
        ACT_EOF          = 3'd6
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_SPLIT = 2'd1,
        ST_NONE  = 2'd2,
        ST_EOS   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CTL_IDLE,
        CTL_EXEC,
        CTL_SCAN,
        CTL_FINISH,
        CTL_OUT
    } ctl_state_t;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic scan_step;
        logic scan_finish;
        logic push_out;
    } dp_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== design/mrrpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrrpm_ctrl
// Sequencer: accept, execute, optional write limit scan, result hand-off.
// ----------------------------------------------------------------------------
module mrrpm_ctrl #(
    parameter int NUM_READERS = mrrpm_pkg::NUM_READERS_DEF,
    localparam int RW = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  mrrpm_pkg::dp_stat_t stat,
    output mrrpm_pkg::dp_cmd_t  cmd,
    output logic [RW-1:0]       scan_idx
);

    localparam logic [RW-1:0] LAST_IDX = RW'(NUM_READERS - 1);

    mrrpm_pkg::ctl_state_t state_reg, state_next;
    logic [RW-1:0]         idx_reg, idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mrrpm_pkg::CTL_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            mrrpm_pkg::CTL_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = mrrpm_pkg::CTL_EXEC;
                end
            end
            mrrpm_pkg::CTL_EXEC: begin
                cmd.exec = 1'b1;
                idx_next = '0;
                if (stat.need_scan) begin
                    state_next = mrrpm_pkg::CTL_SCAN;
                end else begin
                    state_next = mrrpm_pkg::CTL_OUT;
                end
            end
            mrrpm_pkg::CTL_SCAN: begin
                cmd.scan_step = 1'b1;
                if (idx_reg == LAST_IDX) begin
                    state_next = mrrpm_pkg::CTL_FINISH;
                end else begin
                    idx_next = idx_reg + RW'(1);
                end
            end
            mrrpm_pkg::CTL_FINISH: begin
                cmd.scan_finish = 1'b1;
                state_next      = mrrpm_pkg::CTL_OUT;
            end
            mrrpm_pkg::CTL_OUT: begin
                if (stat.out_free) begin
                    cmd.push_out = 1'b1;
                    state_next   = mrrpm_pkg::CTL_IDLE;
                end
            end
            default: begin
                state_next = mrrpm_pkg::CTL_IDLE;
            end
        endcase
    end

    assign scan_idx = idx_reg;

endmodule

// ===== design/mrrpm_datapath.sv =====
// ----------------------------------------------------------------------------
// mrrpm_datapath
// Ring pointer state, access execution, write limit scan and output register.
// ----------------------------------------------------------------------------
module mrrpm_datapath #(
    parameter int NUM_READERS = mrrpm_pkg::NUM_READERS_DEF,
    localparam int RW = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1,
    localparam int CW = $clog2(NUM_READERS + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [mrrpm_pkg::BUF_SIZE_W-1:0]    cfg_wdata,
    input  logic [mrrpm_pkg::ACTION_W-1:0]      in_action,
    input  logic [mrrpm_pkg::SLOT_W-1:0]        in_slot,
    input  logic [mrrpm_pkg::AMOUNT_W-1:0]      in_amount,
    input  logic                                m_tready,
    input  mrrpm_pkg::dp_cmd_t                  cmd,
    input  logic [RW-1:0]                       scan_idx,
    output mrrpm_pkg::dp_stat_t                 stat,
    output logic                                out_valid,
    output logic [mrrpm_pkg::STATUS_W-1:0]      out_status,
    output logic [mrrpm_pkg::AMOUNT_W-1:0]      out_granted,
    output logic [mrrpm_pkg::SLOT_W-1:0]        out_given
);

    localparam int PW = mrrpm_pkg::POS_W;
    localparam int SW = mrrpm_pkg::SPACE_W;

    // configuration and input word
    logic [mrrpm_pkg::BUF_SIZE_W-1:0] buf_size_reg;
    mrrpm_pkg::action_t               act_reg, act_next;
    logic [mrrpm_pkg::SLOT_W-1:0]     slot_reg, slot_next;
    logic [mrrpm_pkg::AMOUNT_W-1:0]   amount_reg, amount_next;

    // ring state
    logic [PW-1:0]          write_pos_reg, write_pos_next;
    logic [PW-1:0]          write_limit_reg, write_limit_next;
    logic [CW-1:0]          limit_refs_reg, limit_refs_next;
    logic                   ring_empty_reg, ring_empty_next;
    logic                   ring_full_reg, ring_full_next;
    logic                   stream_ended_reg, stream_ended_next;
    logic [PW-1:0]          reader_pos_reg [NUM_READERS];
    logic [PW-1:0]          reader_pos_next [NUM_READERS];
    logic [NUM_READERS-1:0] reader_waiting_reg, reader_waiting_next;
    logic [NUM_READERS-1:0] reader_active_reg, reader_active_next;

    // scan accumulators
    logic [PW:0]            scan_lo_reg, scan_lo_next;
    logic [CW-1:0]          scan_cnt_reg, scan_cnt_next;

    // pending result and output register
    mrrpm_pkg::status_t             res_status_reg, res_status_next;
    logic [mrrpm_pkg::AMOUNT_W-1:0] res_granted_reg, res_granted_next;
    logic [mrrpm_pkg::SLOT_W-1:0]   res_given_reg, res_given_next;
    logic                           out_valid_reg, out_valid_next;
    mrrpm_pkg::status_t             out_status_reg;
    logic [mrrpm_pkg::AMOUNT_W-1:0] out_granted_reg;
    logic [mrrpm_pkg::SLOT_W-1:0]   out_given_reg;

    logic [PW-1:0] size;
    logic [RW-1:0] slot_idx;
    logic          slot_ok;
    logic [PW-1:0] rp;
    logic          drop;
    logic          need_scan;

    always_comb begin
        if (buf_size_reg == '0) begin
            size = PW'(1);
        end else if (buf_size_reg > mrrpm_pkg::BUF_SIZE_W'(mrrpm_pkg::MAX_BYTES)) begin
            size = PW'(mrrpm_pkg::MAX_BYTES);
        end else begin
            size = buf_size_reg;
        end
    end

    assign slot_idx = RW'(slot_reg);
    assign slot_ok  = ({30'd0, slot_reg} < NUM_READERS) && reader_active_reg[slot_idx];
    assign rp       = reader_pos_reg[slot_idx];

    // a successful read commit or detach that leaves the write limit position
    assign drop = slot_ok
        && (((act_reg == mrrpm_pkg::ACT_READ_COMMIT)
             && (({1'b0, rp} + {1'b0, amount_reg}) <= {1'b0, size})
             && (rp == write_limit_reg))
         || ((act_reg == mrrpm_pkg::ACT_DETACH) && (write_limit_reg == rp)));
    assign need_scan = drop && (limit_refs_reg == CW'(1));

    always_comb begin
        logic [PW-1:0]        wp_eff;
        logic signed [SW-1:0] sp_w;
        logic signed [SW-1:0] sp_r;
        logic signed [SW-1:0] amt_s;
        logic signed [SW-1:0] size_s;
        logic                 split_w;
        logic                 split_r;
        logic [PW:0]          wsum;
        logic [PW:0]          rsum;
        logic [PW-1:0]        wnew;
        logic [PW-1:0]        rnew;
        logic                 free_found;
        logic [RW-1:0]        free_idx;
        logic [PW:0]          p;
        logic [PW:0]          lo_f;

        act_next            = act_reg;
        slot_next           = slot_reg;
        amount_next         = amount_reg;
        write_pos_next      = write_pos_reg;
        write_limit_next    = write_limit_reg;
        limit_refs_next     = limit_refs_reg;
        ring_empty_next     = ring_empty_reg;
        ring_full_next      = ring_full_reg;
        stream_ended_next   = stream_ended_reg;
        reader_pos_next     = reader_pos_reg;
        reader_waiting_next = reader_waiting_reg;
        reader_active_next  = reader_active_reg;
        scan_lo_next        = scan_lo_reg;
        scan_cnt_next       = scan_cnt_reg;
        res_status_next     = res_status_reg;
        res_granted_next    = res_granted_reg;
        res_given_next      = res_given_reg;

        amt_s  = $signed(SW'(amount_reg));
        size_s = $signed(SW'(size));

        // write space
        wp_eff = (write_pos_reg == size && write_limit_reg != '0) ? '0 : write_pos_reg;
        sp_w    = $signed(SW'(write_limit_reg)) - $signed(SW'(wp_eff));
        split_w = 1'b0;
        if (sp_w <= 0) begin
            sp_w    = sp_w + size_s;
            split_w = (size_s - $signed(SW'(wp_eff))) < amt_s;
        end

        // read data
        sp_r    = $signed(SW'(write_pos_reg)) - $signed(SW'(rp));
        split_r = 1'b0;
        if (sp_r <= 0) begin
            sp_r    = sp_r + size_s;
            split_r = (size_s - $signed(SW'(rp))) < amt_s;
        end

        wsum = {1'b0, write_pos_reg} + {1'b0, amount_reg};
        rsum = {1'b0, rp} + {1'b0, amount_reg};
        wnew = (wsum == {1'b0, size}) ? '0 : wsum[PW-1:0];
        rnew = (rsum == {1'b0, size}) ? '0 : rsum[PW-1:0];

        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < NUM_READERS; i++) begin
            if (!free_found && !reader_active_reg[i]) begin
                free_found = 1'b1;
                free_idx   = RW'(i);
            end
        end

        if (cmd.load_in) begin
            act_next    = mrrpm_pkg::action_t'(in_action);
            slot_next   = in_slot;
            amount_next = in_amount;
        end

        if (cmd.exec) begin
            res_status_next  = mrrpm_pkg::ST_OK;
            res_granted_next = '0;
            res_given_next   = '0;
            scan_lo_next     = {size, 1'b0};
            scan_cnt_next    = '0;
            case (act_reg)
                mrrpm_pkg::ACT_WRITE_ASK: begin
                    if (ring_full_reg) begin
                        res_status_next = mrrpm_pkg::ST_NONE;
                    end else begin
                        write_pos_next = wp_eff;
                        if (sp_w < amt_s) begin
                            res_status_next  = mrrpm_pkg::ST_NONE;
                            res_granted_next = (sp_w < 0) ? '0 : sp_w[PW-1:0];
                        end else if (split_w) begin
                            res_status_next  = mrrpm_pkg::ST_SPLIT;
                            res_granted_next = size - wp_eff;
                        end else begin
                            res_granted_next = amount_reg;
                        end
                    end
                end
                mrrpm_pkg::ACT_WRITE_COMMIT: begin
                    if (wsum > {1'b0, size}) begin
                        res_status_next = mrrpm_pkg::ST_NONE;
                    end else begin
                        write_pos_next = wnew;
                        if (amount_reg != '0) begin
                            ring_empty_next = 1'b0;
                        end
                        if (wnew == write_limit_reg) begin
                            ring_full_next = 1'b1;
                        end
                        reader_waiting_next = reader_waiting_reg & ~reader_active_reg;
                    end
                end
                mrrpm_pkg::ACT_READ_ASK: begin
                    if (!slot_ok) begin
                        res_status_next = mrrpm_pkg::ST_NONE;
                    end else if (ring_empty_reg || reader_waiting_reg[slot_idx]) begin
                        res_status_next = stream_ended_reg ? mrrpm_pkg::ST_EOS
                                                           : mrrpm_pkg::ST_NONE;
                    end else if (sp_r < amt_s) begin
                        res_status_next  = mrrpm_pkg::ST_NONE;
                        res_granted_next = (sp_r < 0) ? '0 : sp_r[PW-1:0];
                    end else begin
                        if (split_r) begin
                            res_status_next  = mrrpm_pkg::ST_SPLIT;
                            res_granted_next = size - rp;
                        end else begin
                            res_granted_next = amount_reg;
                        end
                        if (sp_r == $signed(SW'(res_granted_next)) && stream_ended_reg) begin
                            res_status_next = mrrpm_pkg::ST_EOS;
                        end
                    end
                end
                mrrpm_pkg::ACT_READ_COMMIT: begin
                    if (!slot_ok || rsum > {1'b0, size}) begin
                        res_status_next = mrrpm_pkg::ST_NONE;
                    end else begin
                        reader_pos_next[slot_idx] = rnew;
                        if (rnew == write_pos_reg) begin
                            reader_waiting_next[slot_idx] = 1'b1;
                        end
                    end
                end
                mrrpm_pkg::ACT_ATTACH: begin
                    if (!free_found) begin
                        res_status_next = mrrpm_pkg::ST_NONE;
                    end else begin
                        reader_active_next[free_idx]  = 1'b1;
                        reader_waiting_next[free_idx] = 1'b0;
                        reader_pos_next[free_idx]     = write_limit_reg;
                        if (limit_refs_reg < CW'(NUM_READERS)) begin
                            limit_refs_next = limit_refs_reg + CW'(1);
                        end
                        res_given_next = mrrpm_pkg::SLOT_W'(free_idx);
                    end
                end
                mrrpm_pkg::ACT_DETACH: begin
                    if (!slot_ok) begin
                        res_status_next = mrrpm_pkg::ST_NONE;
                    end else begin
                        reader_active_next[slot_idx] = 1'b0;
                    end
                end
                mrrpm_pkg::ACT_EOF: begin
                    stream_ended_next = 1'b1;
                end
                default: begin
                    res_status_next = mrrpm_pkg::ST_NONE;
                end
            endcase
            if (drop && limit_refs_reg != '0) begin
                limit_refs_next = limit_refs_reg - CW'(1);
            end
        end

        // minimum over active readers, relative to the write position
        p = {1'b0, reader_pos_reg[scan_idx]};
        if (reader_pos_reg[scan_idx] < write_pos_reg
            || (reader_pos_reg[scan_idx] == write_pos_reg && reader_waiting_reg[scan_idx])) begin
            p = p + {1'b0, size};
        end
        if (cmd.scan_step && reader_active_reg[scan_idx]) begin
            if (p < scan_lo_reg) begin
                scan_lo_next  = p;
                scan_cnt_next = CW'(1);
            end else if (p == scan_lo_reg) begin
                scan_cnt_next = scan_cnt_reg + CW'(1);
            end
        end

        lo_f = (scan_lo_reg >= {1'b0, size}) ? scan_lo_reg - {1'b0, size} : scan_lo_reg;
        if (cmd.scan_finish) begin
            write_limit_next = lo_f[PW-1:0];
            limit_refs_next  = scan_cnt_reg;
            ring_full_next   = 1'b0;
            if (lo_f[PW-1:0] == write_pos_reg) begin
                ring_empty_next = 1'b1;
            end
        end
    end

    always_comb begin
        if (cmd.push_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_size_reg       <= mrrpm_pkg::BUF_SIZE_RST;
            write_pos_reg      <= '0;
            write_limit_reg    <= '0;
            limit_refs_reg     <= '0;
            ring_empty_reg     <= 1'b1;
            ring_full_reg      <= 1'b0;
            stream_ended_reg   <= 1'b0;
            reader_waiting_reg <= '0;
            reader_active_reg  <= '0;
            for (int i = 0; i < NUM_READERS; i++) begin
                reader_pos_reg[i] <= '0;
            end
            out_valid_reg      <= 1'b0;
        end else if (cfg_we) begin
            buf_size_reg       <= cfg_wdata;
            write_pos_reg      <= '0;
            write_limit_reg    <= '0;
            limit_refs_reg     <= '0;
            ring_empty_reg     <= 1'b1;
            ring_full_reg      <= 1'b0;
            stream_ended_reg   <= 1'b0;
            reader_waiting_reg <= '0;
            reader_active_reg  <= '0;
            for (int i = 0; i < NUM_READERS; i++) begin
                reader_pos_reg[i] <= '0;
            end
            out_valid_reg      <= out_valid_next;
        end else begin
            write_pos_reg      <= write_pos_next;
            write_limit_reg    <= write_limit_next;
            limit_refs_reg     <= limit_refs_next;
            ring_empty_reg     <= ring_empty_next;
            ring_full_reg      <= ring_full_next;
            stream_ended_reg   <= stream_ended_next;
            reader_waiting_reg <= reader_waiting_next;
            reader_active_reg  <= reader_active_next;
            reader_pos_reg     <= reader_pos_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg         <= act_next;
        slot_reg        <= slot_next;
        amount_reg      <= amount_next;
        scan_lo_reg     <= scan_lo_next;
        scan_cnt_reg    <= scan_cnt_next;
        res_status_reg  <= res_status_next;
        res_granted_reg <= res_granted_next;
        res_given_reg   <= res_given_next;
        if (cmd.push_out) begin
            out_status_reg  <= res_status_reg;
            out_granted_reg <= res_granted_reg;
            out_given_reg   <= res_given_reg;
        end
    end

    assign stat        = '{need_scan: need_scan, out_free: (!out_valid_reg || m_tready)};
    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_granted = out_granted_reg;
    assign out_given   = out_given_reg;

endmodule

// ===== design/multi_reader_ring_pointer_manager_core.sv =====
// ----------------------------------------------------------------------------
// multi_reader_ring_pointer_manager_core
// Space and pointer manager for a byte ring, one writer, several readers.
//
//   channel  dir  fields (tdata / tuser)
//   s_       in   amount / action, reader_slot
//   m_       out  granted, slot_given / status
//   cfg_     in   buf_size (write only)
//
// A word passes through accept, execute and hand-off to the output register.
// A read commit or detach that releases the last reader on the write limit
// adds a limit scan, one reader slot per cycle, and then a finish step.
// Reset and a buf_size write return the ring to empty; no clearing pass.
// The output register lets the next word in while a result waits on m_tready.
// ----------------------------------------------------------------------------
module multi_reader_ring_pointer_manager_core #(
    parameter int NUM_READERS = mrrpm_pkg::NUM_READERS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,   // buf_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [12:0] amount
    input  logic [4:0]  s_tuser,     // [2:0] action, [4:3] reader_slot
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [12:0] granted, [14:13] slot_given
    output logic [1:0]  m_tuser      // [1:0] status
);

    localparam int RW = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;

    mrrpm_pkg::dp_cmd_t  cmd;
    mrrpm_pkg::dp_stat_t stat;
    logic [RW-1:0]       scan_idx;
    logic [12:0]         granted;
    logic [1:0]          given;

    mrrpm_ctrl #(
        .NUM_READERS(NUM_READERS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd),
        .scan_idx (scan_idx)
    );

    mrrpm_datapath #(
        .NUM_READERS(NUM_READERS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_action   (s_tuser[2:0]),
        .in_slot     (s_tuser[4:3]),
        .in_amount   (s_tdata[12:0]),
        .m_tready    (m_tready),
        .cmd         (cmd),
        .scan_idx    (scan_idx),
        .stat        (stat),
        .out_valid   (m_tvalid),
        .out_status  (m_tuser),
        .out_granted (granted),
        .out_given   (given)
    );

    assign m_tdata = {1'b0, given, granted};

endmodule
